FILE: hw/rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PUSH   = 2'd0;
    localparam t_mode MODE_POP    = 2'd1;
    localparam t_mode MODE_REMOVE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_EMPTY     = 2'd1;
    localparam t_status STAT_NOT_FOUND = 2'd2;
    localparam t_status STAT_FULL      = 2'd3;

    typedef struct packed {
        t_mode                      mode;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    typedef struct packed {
        t_status                    status;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [VALUE_W-1:0]  minimum;
        logic                       is_empty;
    } t_out;

endpackage

FILE: hw/rtl/binary_min_heap_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Bounded binary min-heap of signed 32-bit values: push, pop minimum, remove.
// ----------------------------------------------------------------------------
// One operation is worked at a time; a new one is taken once the previous
// result sits in the output register, so a held result does not block it.
// Timing is set by the single heap memory (one write port, two read ports,
// registered reads): a push sifts up through S_UP, one level per step, a
// pop sifts down through S_DN_RD and S_DN_CMP per level, both children read
// together, and a remove adds a linear scan of one entry per cycle over the
// stored entries before the same repair. Rejected operations (full, empty)
// go straight to S_FIN. No clearing pass is needed after reset: only entries
// below the count are ever used.
module binary_min_heap_queue_core #(
    parameter int CAPACITY = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  bmhq_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output bmhq_pkg::t_out   o_data
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_TAKE   = 8'b0000_0100,
        S_UP     = 8'b0000_1000,
        S_PLACE  = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    // heap memory
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]             rd_addr_a, rd_addr_b, mem_wa;
    logic signed [VALUE_W-1:0] mem_wd;
    logic                      mem_we;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_cur, n_cur;
    logic signed [VALUE_W-1:0] r_root;
    logic [AW-1:0]             r_pos, n_pos;
    logic [AW-1:0]             r_par, n_par;
    logic [CW-1:0]             r_scan_idx, n_scan_idx;
    logic [AW-1:0]             r_cmp_idx, n_cmp_idx;
    logic                      r_take, n_take;
    logic                      r_moved, n_moved;

    logic                      slot_load;
    logic                      slot_free;
    t_out                      res;

    logic [AW+1:0]             lc_w, rc_w, cnt_w;
    logic                      rc_ok, pick_right;
    logic signed [VALUE_W-1:0] pick_val;
    logic [AW-1:0]             pick_idx, up_par;
    logic [CW-1:0]             last_c, pos_c;
    logic [CW+COUNT_W-1:0]     cnt_ext;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // copy of the root entry, kept in step with every write to slot zero
    always_ff @(posedge i_clk) begin
        if (mem_we && mem_wa == '0) begin
            r_root <= mem_wd;
        end
    end

    assign lc_w   = {1'b0, r_pos, 1'b1};
    assign rc_w   = lc_w + (AW+2)'(1);
    assign cnt_w  = (AW+2)'(r_count);
    assign rc_ok  = rc_w < cnt_w;
    // right child wins a tie
    assign pick_right = rc_ok && !(r_rd_a < r_rd_b);
    assign pick_val   = pick_right ? r_rd_b : r_rd_a;
    assign pick_idx   = pick_right ? AW'(rc_w) : AW'(lc_w);
    assign up_par     = (r_par - AW'(1)) >> 1;
    assign last_c     = r_count - CW'(1);
    assign pos_c      = CW'(r_pos);

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_status   = r_status;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_par      = r_par;
        n_scan_idx = r_scan_idx;
        n_cmp_idx  = r_cmp_idx;
        n_take     = r_take;
        n_moved    = r_moved;
        mem_we     = 1'b0;
        mem_wa     = r_pos;
        mem_wd     = r_cur;
        rd_addr_a  = r_par;
        rd_addr_b  = rc_ok ? AW'(rc_w) : AW'(lc_w);
        slot_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = STAT_OK;
                    n_take   = 1'b1;
                    n_moved  = 1'b0;
                    n_state  = S_FIN;
                    priority if (i_data.mode == MODE_PUSH) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_take  = 1'b0;
                            n_cur   = i_data.value;
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                mem_we = 1'b1;
                                mem_wa = '0;
                                mem_wd = i_data.value;
                            end else begin
                                n_par     = AW'((r_count - CW'(1)) >> 1);
                                rd_addr_a = AW'((r_count - CW'(1)) >> 1);
                                n_state   = S_UP;
                            end
                        end
                    end else if (i_data.mode == MODE_POP ||
                                 i_data.mode == MODE_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else if (i_data.mode == MODE_POP) begin
                            n_pos     = '0;
                            rd_addr_a = AW'(last_c);
                            n_state   = S_TAKE;
                        end else begin
                            n_cur      = i_data.value;
                            rd_addr_a  = '0;
                            n_cmp_idx  = '0;
                            n_scan_idx = CW'(1);
                            n_state    = S_SCAN;
                        end
                    end else begin
                        n_status = STAT_OK;
                    end
                end
            end
            S_SCAN: begin
                // one read issued and one compare made each cycle
                priority if (r_rd_a == r_cur) begin
                    n_pos     = r_cmp_idx;
                    rd_addr_a = AW'(last_c);
                    n_state   = S_TAKE;
                end else if (r_scan_idx < r_count) begin
                    rd_addr_a  = AW'(r_scan_idx);
                    n_cmp_idx  = AW'(r_scan_idx);
                    n_scan_idx = r_scan_idx + CW'(1);
                end else begin
                    n_status = STAT_NOT_FOUND;
                    n_state  = S_FIN;
                end
            end
            S_TAKE: begin
                // last entry fills the gap at r_pos
                n_cur   = r_rd_a;
                n_count = last_c;
                if (pos_c < last_c) begin
                    if (r_pos == '0) begin
                        n_state = S_DN_RD;
                    end else begin
                        n_par     = (r_pos - AW'(1)) >> 1;
                        rd_addr_a = (r_pos - AW'(1)) >> 1;
                        n_state   = S_UP;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UP: begin
                if (r_rd_a > r_cur) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_pos;
                    mem_wd  = r_rd_a;
                    n_pos   = r_par;
                    n_moved = 1'b1;
                    if (r_par == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_par     = up_par;
                        rd_addr_a = up_par;
                    end
                end else if (r_take && !r_moved) begin
                    // a filled gap that did not rise may have to sink
                    n_state = S_DN_RD;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_PLACE: begin
                mem_we  = 1'b1;
                n_state = S_FIN;
            end
            S_DN_RD: begin
                if (lc_w >= cnt_w) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    rd_addr_a = AW'(lc_w);
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (pick_val < r_cur) begin
                    mem_we  = 1'b1;
                    mem_wd  = pick_val;
                    n_pos   = pick_idx;
                    n_state = S_DN_RD;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    slot_load = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_take  <= 1'b0;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_take  <= n_take;
            r_moved <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_cur      <= n_cur;
        r_pos      <= n_pos;
        r_par      <= n_par;
        r_scan_idx <= n_scan_idx;
        r_cmp_idx  <= n_cmp_idx;
    end

    assign cnt_ext         = (CW+COUNT_W)'(r_count);
    assign res.status      = r_status;
    assign res.entry_count = cnt_ext[COUNT_W-1:0];
    assign res.minimum     = (r_count != '0) ? r_root : '0;
    assign res.is_empty    = (r_count == '0);

    bmhq_out_slot u_out_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (slot_load),
        .i_data  (res),
        .o_free  (slot_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted operation left sequencer idle");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared without a finished operation");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_TAKE) |=> $stable(r_count))
        else $error("entry count changed mid-operation");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= r_count))
        else $error("scan ran past stored entries");
`endif

endmodule

FILE: hw/rtl/bmhq_out_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_out_slot
// Result register: holds one finished result until the downstream transfer.
// ----------------------------------------------------------------------------
module bmhq_out_slot (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bmhq_pkg::t_out   i_data,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output bmhq_pkg::t_out   o_data
);
    import bmhq_pkg::*;

    logic r_vld;
    t_out r_data;

    // slot can take a new result when empty or emptying this cycle
    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load && o_free) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_data <= i_data;
        end
    end

endmodule
